// File: rtl/core/ovt_pkg.sv
// Shared types and constants of the orbit vertex transform.
// Used by the top level, the sine unit, the divider and the checker.
package ovt_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int ANGLE_WIDTH_DEF = 16;
   localparam int SCALE_WIDTH     = 24;
   localparam int TRIG_WIDTH      = 18;
   localparam int FRAC_BITS       = 16;
   localparam int CSR_ADDR_WIDTH  = 3;

   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 24'd32768;

   // Polynomial sine coefficients, Q16.
   localparam logic [16:0] SIN_A = 17'd102944;
   localparam logic [15:0] SIN_B = 16'd42047;
   localparam logic [12:0] SIN_C = 13'd4639;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_ORBIT_ANGLE    = 3'd0,
      CSR_LOCAL_ANGLE    = 3'd1,
      CSR_SCALE_FACTOR   = 3'd2,
      CSR_ORBIT_DISTANCE = 3'd3,
      CSR_FOLLOW_ORBIT   = 3'd4
   } csr_index_type;

   typedef logic signed [TRIG_WIDTH-1:0] trig_type;

endpackage

// File: rtl/core/orbit_vertex_transform_2d.sv
// Top level of the 2D orbit vertex transform.
// Depends on ovt_pkg, ovt_sin and ovt_div.
//
// Usage: one vertex beat per cycle on the req_ stream while req_tready is high,
// one world-space vertex beat on the rsp_ stream for each of them, in order.
// The csr_ port writes the orbit angle, local angle, scale, orbit distance and
// follow flag; write it only while no vertex is in flight.
// The offset division sets the pipeline depth: it resolves one quotient bit
// per stage over COORD_WIDTH + 16 stages.
// Throughput: one vertex per cycle, held while the receiver stalls.
// Reset clears all valid bits and loads the register defaults (scale 0.5).
// When the receiver stalls, the whole pipeline holds and req_tready drops in
// the same cycle; no beat is lost or repeated.
module orbit_vertex_transform_2d #(
   parameter int COORD_WIDTH = ovt_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ovt_pkg::ANGLE_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // vertex_x, vertex_y, object_x, object_y, offset_x, offset_y, orientation
   input  logic [((6*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // world_x, world_y
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0]             rsp_tdata,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   input  logic                                          csr_wen,
   input  logic [ovt_pkg::CSR_ADDR_WIDTH-1:0]            csr_addr,
   input  logic [(COORD_WIDTH > ovt_pkg::SCALE_WIDTH ? COORD_WIDTH
                  : ovt_pkg::SCALE_WIDTH)-1:0]           csr_wdata
);
   import ovt_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int AW  = ANGLE_WIDTH;
   localparam int RSP_W = ((2*CW+7)/8)*8;
   localparam int TL  = 5;             // sine unit register stages
   localparam int DL  = CW + 17;       // divider stage holding the origin
   localparam int LAT = DL + 5;        // output stage
   localparam logic [AW-1:0] QUARTER = AW'(1) << (AW-2);

   // Configuration registers.
   logic [AW-1:0]          orbit_angle_ff, local_angle_ff;
   logic [SCALE_WIDTH-1:0] scale_ff;
   logic signed [CW-1:0]   dist_ff;
   logic                   follow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         orbit_angle_ff <= '0;
         local_angle_ff <= '0;
         scale_ff       <= SCALE_RESET;
         dist_ff        <= '0;
         follow_ff      <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            CSR_ORBIT_ANGLE:    orbit_angle_ff <= csr_wdata[AW-1:0];
            CSR_LOCAL_ANGLE:    local_angle_ff <= csr_wdata[AW-1:0];
            CSR_SCALE_FACTOR:   scale_ff       <= csr_wdata[SCALE_WIDTH-1:0];
            CSR_ORBIT_DISTANCE: dist_ff        <= csr_wdata[CW-1:0];
            CSR_FOLLOW_ORBIT:   follow_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Pipeline control: everything advances together.
   logic en;
   logic vld_ff [0:LAT];

   assign en         = !vld_ff[LAT] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k <= LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // Stage 0: input register.
   logic signed [CW-1:0] x0_ff, y0_ff, px0_ff, py0_ff, offx0_ff, offy0_ff;
   logic [AW-1:0]        orient0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff      <= req_tdata[CW-1:0];
         y0_ff      <= req_tdata[2*CW-1:CW];
         px0_ff     <= req_tdata[3*CW-1:2*CW];
         py0_ff     <= req_tdata[4*CW-1:3*CW];
         offx0_ff   <= req_tdata[5*CW-1:4*CW];
         offy0_ff   <= req_tdata[6*CW-1:5*CW];
         orient0_ff <= req_tdata[6*CW+AW-1:6*CW];
      end
   end

   // Angles.
   logic [AW-1:0] ang_o, ang_la;
   always_comb begin
      ang_o  = orbit_angle_ff + orient0_ff;
      ang_la = local_angle_ff + (follow_ff ? ang_o : '0);
   end

   trig_type s_or, c_or, s_la, c_la, s_o, c_o;

   ovt_sin #(.ANGLE_WIDTH(AW)) u_sin_or (.clock, .en, .angle(orient0_ff), .sin_out(s_or));
   ovt_sin #(.ANGLE_WIDTH(AW)) u_cos_or (.clock, .en, .angle(orient0_ff + QUARTER),
                                         .sin_out(c_or));
   ovt_sin #(.ANGLE_WIDTH(AW)) u_sin_la (.clock, .en, .angle(ang_la), .sin_out(s_la));
   ovt_sin #(.ANGLE_WIDTH(AW)) u_cos_la (.clock, .en, .angle(ang_la + QUARTER),
                                         .sin_out(c_la));
   ovt_sin #(.ANGLE_WIDTH(AW)) u_sin_o  (.clock, .en, .angle(ang_o), .sin_out(s_o));
   ovt_sin #(.ANGLE_WIDTH(AW)) u_cos_o  (.clock, .en, .angle(ang_o + QUARTER),
                                         .sin_out(c_o));

   // Origin division, offset * 2^16 / scale truncated toward zero.
   logic [CW-1:0] divx, divy;

   ovt_div #(.COORD_WIDTH(CW)) u_div_x (
      .clock, .en, .neg_in(offx0_ff[CW-1]),
      .mag_in(offx0_ff[CW-1] ? -offx0_ff : offx0_ff),
      .divisor(scale_ff), .quot_out(divx));
   ovt_div #(.COORD_WIDTH(CW)) u_div_y (
      .clock, .en, .neg_in(offy0_ff[CW-1]),
      .mag_in(offy0_ff[CW-1] ? -offy0_ff : offy0_ff),
      .divisor(scale_ff), .quot_out(divy));

   // Delay lines.
   logic signed [CW-1:0] xd_ff [1:TL], yd_ff [1:TL];
   logic [CW-1:0]        offs_x_ff [1:DL+4], offs_y_ff [1:DL+4];
   logic signed [CW-1:0] r1x_ff [7:DL], r1y_ff [7:DL];
   trig_type             sla_ff [TL+1:DL+1], cla_ff [TL+1:DL+1];
   trig_type             so_ff [TL+1:DL+3], co_ff [TL+1:DL+3];

   // Rotation and output arithmetic.
   logic signed [CW+17:0] p1_xc_ff, p1_ys_ff, p1_xs_ff, p1_yc_ff;
   logic signed [CW+18:0] r1x_sum, r1y_sum;
   logic signed [CW-1:0]  ux_ff, uy_ff;
   logic signed [CW+17:0] p2_xc_ff, p2_ys_ff, p2_xs_ff, p2_yc_ff;
   logic signed [CW+18:0] r2x_sum, r2y_sum;
   logic signed [CW-1:0]  vx_ff, vy_ff;
   logic signed [CW+24:0] pvx_ff, pvy_ff;
   logic signed [CW+17:0] pdx_ff, pdy_ff;
   logic [CW-1:0]         wx_ff, wy_ff;

   always_comb begin
      r1x_sum = (CW+19)'(p1_xc_ff) - (CW+19)'(p1_ys_ff);
      r1y_sum = (CW+19)'(p1_xs_ff) + (CW+19)'(p1_yc_ff);
      r2x_sum = (CW+19)'(p2_xc_ff) - (CW+19)'(p2_ys_ff);
      r2y_sum = (CW+19)'(p2_xs_ff) + (CW+19)'(p2_yc_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xd_ff[1] <= x0_ff;
         yd_ff[1] <= y0_ff;
         for (int k = 2; k <= TL; k++) begin
            xd_ff[k] <= xd_ff[k-1];
            yd_ff[k] <= yd_ff[k-1];
         end
         offs_x_ff[1] <= offx0_ff + px0_ff;
         offs_y_ff[1] <= offy0_ff + py0_ff;
         for (int k = 2; k <= DL+4; k++) begin
            offs_x_ff[k] <= offs_x_ff[k-1];
            offs_y_ff[k] <= offs_y_ff[k-1];
         end
         sla_ff[TL+1] <= s_la;
         cla_ff[TL+1] <= c_la;
         for (int k = TL+2; k <= DL+1; k++) begin
            sla_ff[k] <= sla_ff[k-1];
            cla_ff[k] <= cla_ff[k-1];
         end
         so_ff[TL+1] <= -s_o;
         co_ff[TL+1] <= c_o;
         for (int k = TL+2; k <= DL+3; k++) begin
            so_ff[k] <= so_ff[k-1];
            co_ff[k] <= co_ff[k-1];
         end

         // Stage 6: first rotation products; stage 7: sums.
         p1_xc_ff <= xd_ff[TL] * c_or;
         p1_ys_ff <= yd_ff[TL] * s_or;
         p1_xs_ff <= xd_ff[TL] * s_or;
         p1_yc_ff <= yd_ff[TL] * c_or;
         r1x_ff[7] <= r1x_sum[CW+15:16];
         r1y_ff[7] <= r1y_sum[CW+15:16];
         for (int k = 8; k <= DL; k++) begin
            r1x_ff[k] <= r1x_ff[k-1];
            r1y_ff[k] <= r1y_ff[k-1];
         end

         // Origin subtraction; a zero scale takes the origin as zero.
         ux_ff <= r1x_ff[DL] - ((scale_ff == '0) ? '0 : divx);
         uy_ff <= r1y_ff[DL] - ((scale_ff == '0) ? '0 : divy);

         // Local rotation.
         p2_xc_ff <= ux_ff * cla_ff[DL+1];
         p2_ys_ff <= uy_ff * sla_ff[DL+1];
         p2_xs_ff <= ux_ff * sla_ff[DL+1];
         p2_yc_ff <= uy_ff * cla_ff[DL+1];
         vx_ff <= r2x_sum[CW+15:16];
         vy_ff <= r2y_sum[CW+15:16];

         // Scale and orbit terms.
         pvx_ff <= vx_ff * $signed({1'b0, scale_ff});
         pvy_ff <= vy_ff * $signed({1'b0, scale_ff});
         pdx_ff <= dist_ff * so_ff[DL+3];
         pdy_ff <= dist_ff * co_ff[DL+3];

         wx_ff <= pvx_ff[CW+15:16] + pdx_ff[CW+15:16] + offs_x_ff[DL+4];
         wy_ff <= pvy_ff[CW+15:16] + pdy_ff[CW+15:16] + offs_y_ff[DL+4];
      end
   end

   assign rsp_tdata = RSP_W'({wy_ff, wx_ff});

endmodule

// File: rtl/core/ovt_sin.sv
// Pipelined polynomial sine of a turn fraction, five register stages.
// Depends on ovt_pkg for the coefficients and the result type.
module ovt_sin #(
   parameter int ANGLE_WIDTH = ovt_pkg::ANGLE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [ANGLE_WIDTH-1:0] angle,
   output ovt_pkg::trig_type      sin_out
);
   import ovt_pkg::*;

   localparam int QB = ANGLE_WIDTH - 2;

   logic [1:0]     quad;
   logic [QB+15:0] zsh;
   logic [16:0]    z_in;

   logic [1:0]  q1_ff, q2_ff, q3_ff, q4_ff;
   logic [16:0] z1_ff, z2_ff, z3_ff, z4_ff;
   logic [16:0] zz2_ff, zz3_ff;
   logic [13:0] t3_ff;
   logic [16:0] t4_ff;
   trig_type    s5_ff;

   logic [33:0] zz_prod;
   logic [29:0] c_prod;
   logic [15:0] b_diff;
   logic [32:0] b_prod;
   logic [16:0] a_diff;
   logic [33:0] a_prod;
   logic [16:0] s_mag;

   always_comb begin
      quad = angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
      zsh  = {angle[QB-1:0], 16'b0} >> QB;
      z_in = quad[0] ? (17'd65536 - zsh[16:0]) : zsh[16:0];
      zz_prod = 34'(z1_ff) * 34'(z1_ff);
      c_prod  = 30'(SIN_C) * 30'(zz2_ff);
      b_diff  = SIN_B - 16'(t3_ff);
      b_prod  = 33'(b_diff) * 33'(zz3_ff);
      a_diff  = SIN_A - t4_ff;
      a_prod  = 34'(a_diff) * 34'(z4_ff);
      s_mag   = a_prod[32:16];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff  <= quad;
         z1_ff  <= z_in;
         q2_ff  <= q1_ff;
         z2_ff  <= z1_ff;
         zz2_ff <= zz_prod[32:16];
         q3_ff  <= q2_ff;
         z3_ff  <= z2_ff;
         zz3_ff <= zz2_ff;
         t3_ff  <= c_prod[29:16];
         q4_ff  <= q3_ff;
         z4_ff  <= z3_ff;
         t4_ff  <= b_prod[32:16];
         s5_ff  <= q4_ff[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
      end
   end

   assign sin_out = s5_ff;

endmodule

// File: rtl/core/ovt_div.sv
// Pipelined restoring divider: (magnitude * 2^16) / divisor, one quotient bit per
// stage, signed result in the last stage. Depends on ovt_pkg.
module ovt_div #(
   parameter int COORD_WIDTH = ovt_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic                                  neg_in,
   input  logic [COORD_WIDTH-1:0]                mag_in,
   input  logic [ovt_pkg::SCALE_WIDTH-1:0]       divisor,
   output logic [COORD_WIDTH-1:0]                quot_out
);
   import ovt_pkg::*;

   localparam int DW = COORD_WIDTH + FRAC_BITS;

   logic [SCALE_WIDTH-1:0] rem_ff [0:DW];
   logic [DW-1:0]          dvd_ff [0:DW];
   logic [COORD_WIDTH-1:0] quo_ff [0:DW];
   logic                   sgn_ff [0:DW];
   logic [COORD_WIDTH-1:0] out_ff;

   // Stage zero is the unregistered input.
   assign rem_ff[0] = '0;
   assign dvd_ff[0] = {mag_in, 16'b0};
   assign quo_ff[0] = '0;
   assign sgn_ff[0] = neg_in;

   for (genvar k = 1; k <= DW; k++) begin : g_stage
      logic [SCALE_WIDTH:0] trial;
      logic                 ge;
      always_comb begin
         trial = {rem_ff[k-1], dvd_ff[k-1][DW-1]};
         ge    = trial >= {1'b0, divisor};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? SCALE_WIDTH'(trial - {1'b0, divisor}) : trial[SCALE_WIDTH-1:0];
            dvd_ff[k] <= {dvd_ff[k-1][DW-2:0], 1'b0};
            quo_ff[k] <= {quo_ff[k-1][COORD_WIDTH-2:0], ge};
            sgn_ff[k] <= sgn_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= sgn_ff[DW] ? -quo_ff[DW] : quo_ff[DW];
      end
   end

   assign quot_out = out_ff;

endmodule

// File: rtl/core/ovt_checker.sv
// Port-level checks of the orbit vertex transform, bound to the top level.
// Depends on ovt_pkg.
module ovt_port_checks #(
   parameter int COORD_WIDTH = ovt_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ovt_pkg::ANGLE_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic [((6*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   input logic req_tvalid,
   input logic req_tready,
   input logic [((2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic csr_wen,
   input logic [ovt_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input logic [(COORD_WIDTH > ovt_pkg::SCALE_WIDTH ? COORD_WIDTH
                 : ovt_pkg::SCALE_WIDTH)-1:0] csr_wdata
);
   import ovt_pkg::*;

   // A stalled result beat stays offered with the same data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed under stall");

   // No results come out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled output freezes the pipeline, so the input is held off.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while pipeline is stalled");

   // With the output slot empty the block always takes input.
   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input refused with free output");

endmodule

bind orbit_vertex_transform_2d ovt_port_checks #(
   .COORD_WIDTH(COORD_WIDTH),
   .ANGLE_WIDTH(ANGLE_WIDTH)
) u_ovt_checker (.*);
